// ----- rtl/register_machine_execute_core_assert.svh -----
// ----------------------------------------------------------------------------
// register_machine_execute_core assertion macros
// shared property forms for the execute core checks
// ----------------------------------------------------------------------------
`ifndef REGISTER_MACHINE_EXECUTE_CORE_ASSERT_SVH
`define REGISTER_MACHINE_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication
`define RME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// shared widths, opcodes and inter-module types of the execute core
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam int WORD_W    = 32;
	localparam int ADDR_W    = 22;
	localparam int IMM_W     = 22;
	localparam int REG_W     = 5;
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [REG_W:0] REG_LIMIT = (REG_W + 1)'(REG_COUNT);

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 56;

	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [4:0] {
		OP_NOP      = 5'd0,
		OP_ADD      = 5'd1,
		OP_SUB      = 5'd2,
		OP_MUL      = 5'd3,
		OP_DIV      = 5'd4,
		OP_JMP      = 5'd5,
		OP_BLT      = 5'd6,
		OP_BLE      = 5'd7,
		OP_LOAD_IMM = 5'd8,
		OP_INC      = 5'd11,
		OP_RET      = 5'd31
	} opcode_t;

	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] idx_a;
		logic [REG_W-1:0] idx_b;
	} rf_rd_t;

	typedef struct packed {
		logic              en;
		logic [REG_W-1:0]  idx;
		logic [WORD_W-1:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/register_machine_execute_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_execute_core
// executes one decoded instruction per input beat against a 32-word register file
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. Each passes through the register file
// read, then execute and write back, then the result beat load, which waits
// while the output register holds an untaken beat. A divide with a nonzero
// divisor runs the 32-step shift-subtract divider before the result beat. The
// register file reads as zero after reset with no clearing pass, so instructions
// are taken as soon as reset is released. A result beat waits in the output
// register without blocking the next instruction's start.
// ----------------------------------------------------------------------------
`include "register_machine_execute_core_assert.svh"

module register_machine_execute_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// fetch_address, opcode, dest_reg, src_reg_a, src_reg_b, long_imm
	input  logic [rme_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// next_pc, halted, ret_value, div_zero
	output logic [rme_pkg::OUT_DATA_W-1:0]     m_tdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                              state_q;
	state_t                              state_d;
	logic                                accept;
	logic                                uses_d;
	rme_pkg::opcode_t                    in_op;
	rme_pkg::rf_rd_t                     rd_req;
	rme_pkg::rf_wr_t                     wr_req;
	logic [rme_pkg::WORD_W-1:0]          val_a;
	logic [rme_pkg::WORD_W-1:0]          val_b;
	logic [rme_pkg::WORD_W-1:0]          prod;
	logic [rme_pkg::WORD_W-1:0]          imm_ext;
	logic [rme_pkg::WORD_W-1:0]          quotient;
	rme_pkg::div_stat_t                  div_stat;
	logic                                div_start;

	logic [rme_pkg::ADDR_W-1:0]          pc_q;
	rme_pkg::opcode_t                    op_q;
	logic [rme_pkg::REG_W-1:0]           rd_q;
	logic [rme_pkg::IMM_W-1:0]           imm_q;

	logic [rme_pkg::ADDR_W-1:0]          res_pc_q;
	logic                                res_halt_q;
	logic [rme_pkg::WORD_W-1:0]          res_ret_q;
	logic                                res_dz_q;
	logic [rme_pkg::ADDR_W-1:0]          next_pc;
	logic                                ex_wr;
	logic [rme_pkg::WORD_W-1:0]          ex_data;
	logic                                ex_dz;

	logic                                m_tvalid_q;
	logic [rme_pkg::OUT_DATA_W-1:0]      m_tdata_q;
	logic                                out_load;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_op    = rme_pkg::opcode_t'(s_tdata[26:22]);

	always_comb begin
		case (in_op)
			rme_pkg::OP_BLT, rme_pkg::OP_BLE,
			rme_pkg::OP_INC, rme_pkg::OP_RET: uses_d = 1'b1;
			default:                          uses_d = 1'b0;
		endcase
	end

	// port a carries the tested register for ops that use dest_reg as a source
	assign rd_req.en    = accept;
	assign rd_req.idx_a = uses_d ? s_tdata[31:27] : s_tdata[36:32];
	assign rd_req.idx_b = s_tdata[41:37];

	rme_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_req    (rd_req),
		.rd_data_a (val_a),
		.rd_data_b (val_b),
		.wr_req    (wr_req)
	);

	assign div_start = (state_q == S_EXEC) && (op_q == rme_pkg::OP_DIV) && (val_b != '0);

	rme_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (val_a),
		.divisor  (val_b),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q  <= s_tdata[21:0];
			op_q  <= in_op;
			rd_q  <= s_tdata[31:27];
			imm_q <= s_tdata[63:42];
		end
	end

	assign prod    = val_a * val_b;
	assign imm_ext = {{(rme_pkg::WORD_W - rme_pkg::IMM_W){imm_q[rme_pkg::IMM_W-1]}}, imm_q};

	always_comb begin
		next_pc = pc_q + 1'b1;
		ex_wr   = 1'b0;
		ex_data = '0;
		ex_dz   = 1'b0;
		case (op_q)
			rme_pkg::OP_ADD: begin
				ex_wr   = 1'b1;
				ex_data = val_a + val_b;
			end
			rme_pkg::OP_SUB: begin
				ex_wr   = 1'b1;
				ex_data = val_a - val_b;
			end
			rme_pkg::OP_MUL: begin
				ex_wr   = 1'b1;
				ex_data = prod;
			end
			rme_pkg::OP_DIV: begin
				// nonzero divisor writes back when the divider finishes
				ex_wr = (val_b == '0);
				ex_dz = (val_b == '0);
			end
			rme_pkg::OP_JMP: begin
				next_pc = imm_q;
			end
			rme_pkg::OP_BLT: begin
				if (val_a[rme_pkg::WORD_W-1]) begin
					next_pc = imm_q;
				end
			end
			rme_pkg::OP_BLE: begin
				if (val_a[rme_pkg::WORD_W-1] || (val_a == '0)) begin
					next_pc = imm_q;
				end
			end
			rme_pkg::OP_LOAD_IMM: begin
				ex_wr   = 1'b1;
				ex_data = imm_ext;
			end
			rme_pkg::OP_INC: begin
				ex_wr   = 1'b1;
				ex_data = val_a + imm_ext;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr_req.idx = rd_q;
		if (state_q == S_DIV) begin
			wr_req.en   = div_stat.done;
			wr_req.data = quotient;
		end else begin
			wr_req.en   = (state_q == S_EXEC) && ex_wr;
			wr_req.data = ex_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			res_pc_q   <= next_pc;
			res_halt_q <= (op_q == rme_pkg::OP_RET);
			res_ret_q  <= (op_q == rme_pkg::OP_RET) ? val_a : '0;
			res_dz_q   <= ex_dz;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = div_start ? S_DIV : S_OUT;
			end
			S_DIV: begin
				if (div_stat.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {res_dz_q, res_ret_q, res_halt_q, res_pc_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`RME_ASSERT_NEXT(a_one_in_flight, accept, !s_tready, "accepted while busy")
	`RME_ASSERT_NOW(a_div_in_state, div_stat.busy, state_q == S_DIV, "divider busy off state")
	`RME_ASSERT_NOW(a_wr_in_state, wr_req.en, (state_q == S_EXEC) || (state_q == S_DIV), "stray write")
	`RME_ASSERT_NOW(a_halt_no_dz, res_halt_q && (state_q == S_OUT), !res_dz_q, "return with dz")

endmodule

// ----- rtl/rme_regfile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_regfile
// register file memory, two registered read ports, one write port
// ----------------------------------------------------------------------------
module rme_regfile (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rme_pkg::rf_rd_t                rd_req,
	output logic [rme_pkg::WORD_W-1:0]     rd_data_a,
	output logic [rme_pkg::WORD_W-1:0]     rd_data_b,
	input  rme_pkg::rf_wr_t                wr_req
);

	logic [rme_pkg::WORD_W-1:0]    mem [rme_pkg::REG_COUNT];
	logic [rme_pkg::REG_COUNT-1:0] vld_q;
	logic [rme_pkg::WORD_W-1:0]    dat_a_q;
	logic [rme_pkg::WORD_W-1:0]    dat_b_q;
	logic                          hit_a_q;
	logic                          hit_b_q;
	logic                          in_a;
	logic                          in_b;
	logic                          in_w;

	assign in_a = {1'b0, rd_req.idx_a} < rme_pkg::REG_LIMIT;
	assign in_b = {1'b0, rd_req.idx_b} < rme_pkg::REG_LIMIT;
	assign in_w = {1'b0, wr_req.idx} < rme_pkg::REG_LIMIT;

	always_ff @(posedge clk) begin
		if (wr_req.en && in_w) begin
			mem[wr_req.idx[rme_pkg::REG_IDX_W-1:0]] <= wr_req.data;
		end
		if (rd_req.en) begin
			dat_a_q <= mem[rd_req.idx_a[rme_pkg::REG_IDX_W-1:0]];
			dat_b_q <= mem[rd_req.idx_b[rme_pkg::REG_IDX_W-1:0]];
		end
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			if (wr_req.en && in_w) begin
				vld_q[wr_req.idx[rme_pkg::REG_IDX_W-1:0]] <= 1'b1;
			end
			if (rd_req.en) begin
				hit_a_q <= in_a && vld_q[rd_req.idx_a[rme_pkg::REG_IDX_W-1:0]];
				hit_b_q <= in_b && vld_q[rd_req.idx_b[rme_pkg::REG_IDX_W-1:0]];
			end
		end
	end

	assign rd_data_a = hit_a_q ? dat_a_q : '0;
	assign rd_data_b = hit_b_q ? dat_b_q : '0;

endmodule

// ----- rtl/rme_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_divider
// iterative signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module rme_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rme_pkg::WORD_W-1:0] dividend,
	input  logic [rme_pkg::WORD_W-1:0] divisor,
	output rme_pkg::div_stat_t         stat,
	output logic [rme_pkg::WORD_W-1:0] quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [rme_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [rme_pkg::WORD_W-1:0]    rem_q;
	logic [rme_pkg::WORD_W-1:0]    quo_q;
	logic [rme_pkg::WORD_W-1:0]    dvs_q;
	logic                          neg_q;
	logic [rme_pkg::WORD_W:0]      shifted;
	logic [rme_pkg::WORD_W:0]      diff;

	assign shifted = {rem_q, quo_q[rme_pkg::WORD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rme_pkg::DIV_CNT_W'(rme_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[rme_pkg::WORD_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q <= divisor[rme_pkg::WORD_W-1] ? (~divisor + 1'b1) : divisor;
			neg_q <= dividend[rme_pkg::WORD_W-1] ^ divisor[rme_pkg::WORD_W-1];
		end else if (busy_q) begin
			if (!diff[rme_pkg::WORD_W]) begin
				rem_q <= diff[rme_pkg::WORD_W-1:0];
				quo_q <= {quo_q[rme_pkg::WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[rme_pkg::WORD_W-1:0];
				quo_q <= {quo_q[rme_pkg::WORD_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ----- tb/sv/execute_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// execute_result_checker
// Watches both stream channels of the execute core. Every accepted instruction
// beat runs through a local model of the machine with its own shadow register
// file. The expected result beat goes into an in-order queue. Every accepted
// result beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module execute_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// fetch_address, opcode, dest_reg, src_reg_a, src_reg_b, long_imm
	input  logic [rme_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// next_pc, halted, ret_value, div_zero
	input  logic [rme_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                             mismatch_count,
	output int                             results_owed
);
	import rme_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] next_pc;
		logic              halted;
		logic [WORD_W-1:0] ret_value;
		logic              div_zero;
	} exec_result_t;

	logic [WORD_W-1:0] shadow_regs [REG_COUNT];
	exec_result_t      owed_results [$];

	function automatic logic [WORD_W-1:0] read_shadow(input logic [REG_W-1:0] idx);
		return (idx < REG_COUNT) ? shadow_regs[idx] : '0;
	endfunction

	task automatic write_shadow(input logic [REG_W-1:0] idx, input logic [WORD_W-1:0] val);
		if (idx < REG_COUNT) begin
			shadow_regs[idx] = val;
		end
	endtask

	// signed divide truncating toward zero, built on magnitudes
	function automatic logic [WORD_W-1:0] trunc_divide(input logic [WORD_W-1:0] num,
		input logic [WORD_W-1:0] den);
		logic [WORD_W-1:0] num_mag;
		logic [WORD_W-1:0] den_mag;
		logic [WORD_W-1:0] quot;
		num_mag = num[WORD_W-1] ? -num : num;
		den_mag = den[WORD_W-1] ? -den : den;
		quot = num_mag / den_mag;
		return (num[WORD_W-1] ^ den[WORD_W-1]) ? -quot : quot;
	endfunction

	task automatic execute_instr(input logic [IN_DATA_W-1:0] beat, output exec_result_t res);
		logic [ADDR_W-1:0] pc;
		opcode_t           op;
		logic [REG_W-1:0]  rd;
		logic [WORD_W-1:0] va;
		logic [WORD_W-1:0] vb;
		logic [WORD_W-1:0] vd;
		logic [WORD_W-1:0] imm_ext;
		logic [WORD_W-1:0] prod;
		pc      = beat[21:0];
		op      = opcode_t'(beat[26:22]);
		rd      = beat[31:27];
		va      = read_shadow(beat[36:32]);
		vb      = read_shadow(beat[41:37]);
		vd      = read_shadow(rd);
		imm_ext = {{(WORD_W-IMM_W){beat[63]}}, beat[63:42]};
		res     = '0;
		res.next_pc = pc + 1'b1;
		case (op)
			OP_ADD: write_shadow(rd, va + vb);
			OP_SUB: write_shadow(rd, va - vb);
			OP_MUL: begin
				prod = va * vb;
				write_shadow(rd, prod);
			end
			OP_DIV: begin
				if (vb == '0) begin
					write_shadow(rd, '0);
					res.div_zero = 1'b1;
				end else begin
					write_shadow(rd, trunc_divide(va, vb));
				end
			end
			OP_JMP: res.next_pc = beat[63:42];
			OP_BLT: begin
				if (vd[WORD_W-1]) begin
					res.next_pc = beat[63:42];
				end
			end
			OP_BLE: begin
				if (vd[WORD_W-1] || vd == '0) begin
					res.next_pc = beat[63:42];
				end
			end
			OP_LOAD_IMM: write_shadow(rd, imm_ext);
			OP_INC:      write_shadow(rd, vd + imm_ext);
			OP_RET: begin
				res.halted    = 1'b1;
				res.ret_value = vd;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_result_t exp_res;
		exec_result_t got_res;
		if (!arst_n) begin
			foreach (shadow_regs[i]) shadow_regs[i] = '0;
			owed_results.delete();
			mismatch_count = 0;
			results_owed   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res.next_pc   = m_tdata[21:0];
				got_res.halted    = m_tdata[22];
				got_res.ret_value = m_tdata[54:23];
				got_res.div_zero  = m_tdata[55];
				if (owed_results.size() == 0) begin
					$error("result beat with no instruction outstanding: %h", m_tdata);
					mismatch_count++;
				end else begin
					exp_res = owed_results.pop_front();
					if (got_res.next_pc !== exp_res.next_pc) begin
						$error("next_pc: expected %h, got %h", exp_res.next_pc, got_res.next_pc);
						mismatch_count++;
					end
					if (got_res.halted !== exp_res.halted) begin
						$error("halted: expected %b, got %b", exp_res.halted, got_res.halted);
						mismatch_count++;
					end
					if (got_res.ret_value !== exp_res.ret_value) begin
						$error("ret_value: expected %h, got %h", exp_res.ret_value,
							got_res.ret_value);
						mismatch_count++;
					end
					if (got_res.div_zero !== exp_res.div_zero) begin
						$error("div_zero: expected %b, got %b", exp_res.div_zero,
							got_res.div_zero);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				execute_instr(s_tdata, exp_res);
				owed_results.push_back(exp_res);
			end
			results_owed = owed_results.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives instruction beats into the execute core and accepts result beats.
// A directed program covers the arithmetic corners, every branch outcome and
// three unknown opcodes; random programs follow with varied idle and stall
// patterns and one long output stall. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb;
	import rme_pkg::*;

	localparam int RANDOM_INSTRS  = 630;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int mismatch_count;
	int results_owed;
	int tx_idle_pct = 32;
	int rx_idle_pct = 45;
	int phase = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	opcode_t known_ops [11] = '{OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JMP,
		OP_BLT, OP_BLE, OP_LOAD_IMM, OP_INC, OP_RET};

	always #6 clk = ~clk;

	register_machine_execute_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	execute_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// result side: random stalls, plus one long hold when the last phase opens
	always @(posedge clk) begin
		if (arst_n) begin
			if (phase == 2 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic issue(input logic [ADDR_W-1:0] pc, input opcode_t op,
		input logic [REG_W-1:0] rd, input logic [REG_W-1:0] ra,
		input logic [REG_W-1:0] rb, input logic [IMM_W-1:0] imm);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {imm, rb, ra, rd, op, pc};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic issue_random(input logic [ADDR_W-1:0] pc);
		opcode_t          op;
		logic [IMM_W-1:0] imm;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			op = OP_LOAD_IMM;
		end else if (pick < 90) begin
			op = known_ops[$urandom_range(0, 10)];
		end else begin
			op = opcode_t'($urandom_range(0, 31));
		end
		// small immediates give small and zero divisors
		if ($urandom_range(0, 2) == 0) begin
			imm = IMM_W'($urandom_range(0, 16)) - IMM_W'(8);
		end else begin
			imm = IMM_W'($urandom);
		end
		issue(pc, op, REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), imm);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// build most negative word, then divide it by minus one
		issue(22'd0,  OP_LOAD_IMM, 5'd1,  5'd0,  5'd0,  22'h200000);
		issue(22'd1,  OP_LOAD_IMM, 5'd2,  5'd0,  5'd0,  22'd1024);
		issue(22'd2,  OP_MUL,      5'd3,  5'd1,  5'd2,  22'd0);
		issue(22'd3,  OP_LOAD_IMM, 5'd4,  5'd0,  5'd0,  22'h3FFFFF);
		issue(22'd4,  OP_DIV,      5'd5,  5'd3,  5'd4,  22'd0);
		issue(22'd5,  OP_DIV,      5'd6,  5'd1,  5'd0,  22'd0);
		issue(22'd6,  OP_LOAD_IMM, 5'd31, 5'd0,  5'd0,  22'h1FFFFF);
		issue(22'd7,  OP_ADD,      5'd7,  5'd31, 5'd3,  22'd0);
		issue(22'd8,  OP_SUB,      5'd8,  5'd0,  5'd31, 22'd0);
		issue(22'd9,  OP_MUL,      5'd9,  5'd31, 5'd31, 22'd0);
		issue(22'd10, OP_DIV,      5'd10, 5'd8,  5'd2,  22'd0);
		issue(22'd11, OP_INC,      5'd31, 5'd0,  5'd0,  22'h200000);
		issue(22'd12, OP_INC,      5'd0,  5'd0,  5'd0,  22'h1FFFFF);
		// jump with negative target from the top address
		issue(22'h3FFFFF, OP_JMP, 5'd0, 5'd0, 5'd0, 22'h3FFFFF);
		issue(22'h3FFFFF, OP_NOP, 5'd0, 5'd0, 5'd0, 22'd0);
		issue(22'd13, OP_BLT,   5'd31, 5'd0,  5'd0,  22'h12345);
		issue(22'd14, OP_BLT,   5'd2,  5'd0,  5'd0,  22'h2AAAAA);
		issue(22'd15, OP_BLE,   5'd12, 5'd0,  5'd0,  22'h155555);
		issue(22'd16, OP_BLE,   5'd3,  5'd0,  5'd0,  22'h000100);
		issue(22'd17, OP_BLE,   5'd2,  5'd0,  5'd0,  22'h000200);
		issue(22'd18, opcode_t'(5'd9),  5'd1, 5'd2, 5'd3, 22'h3FFFFF);
		issue(22'd19, opcode_t'(5'd10), 5'd1, 5'd2, 5'd3, 22'h3FFFFF);
		issue(22'd20, opcode_t'(5'd12), 5'd1, 5'd2, 5'd3, 22'h3FFFFF);
		issue(22'd21, OP_RET,   5'd5,  5'd0,  5'd0,  22'd0);
		issue(22'd22, OP_RET,   5'd0,  5'd0,  5'd0,  22'd0);

		for (int i = 0; i < RANDOM_INSTRS; i++) begin
			if (i == 190) begin
				phase       = 1;
				tx_idle_pct = 45;
				rx_idle_pct = 32;
			end else if (i == 400) begin
				phase       = 2;
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			issue_random(ADDR_W'($urandom));
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rme_pkg.sv
rtl/rme_regfile.sv
rtl/rme_divider.sv
rtl/register_machine_execute_core.sv
tb/sv/execute_result_checker.sv
tb/sv/tb.sv
